// ===== hw/rtl/fmf_pkg.sv =====
// Shared types, constants and saturation helpers for the face momentum flux accumulator.
package fmf_pkg;

    // Fixed-point format of the inputs and registers
    localparam int FRAC_BITS    = 16;
    localparam int FORCE_SHIFT  = 4 * FRAC_BITS - 32;
    localparam int MOMENT_SHIFT = FRAC_BITS;

    localparam int DATA_W = 32;
    localparam int DEN_W  = 31;
    localparam int RES_W  = 64;
    localparam int COMPS  = 3;

    // Multiply-accumulate unit: 32-bit digits of a wide operand times a 33-bit operand
    localparam int DIG_W  = 32;
    localparam int OPB_W  = DIG_W + 1;
    localparam int ACC_W  = 128;
    localparam int NDIG   = ACC_W / DIG_W;
    localparam int DSEL_W = $clog2(NDIG);

    // Digit counts of the wide operand, stored as count minus one
    localparam logic [DSEL_W-1:0] DIGITS_1 = DSEL_W'(0);
    localparam logic [DSEL_W-1:0] DIGITS_2 = DSEL_W'(1);
    localparam logic [DSEL_W-1:0] DIGITS_3 = DSEL_W'(2);
    localparam logic [DSEL_W-1:0] DIGITS_4 = DSEL_W'(3);

    // Widths of intermediate values held in the back end
    localparam int VV_W  = 65;
    localparam int VS2_W = 67;
    localparam int BQ_W  = 98;

    // Front to back queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CV_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CV_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CV_Z    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY = CFG_IDX_W'(6);

    localparam logic [DEN_W-1:0] DENSITY_RESET = DEN_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic [COMPS-1:0][DATA_W-1:0] cv;
        logic [COMPS-1:0][DATA_W-1:0] org;
        logic [DEN_W-1:0]             density;
    } t_cfg;

    typedef struct packed {
        logic [COMPS-1:0][DATA_W-1:0] vel;
        logic [COMPS-1:0][DATA_W-1:0] area;
        logic [COMPS-1:0][DATA_W-1:0] centre;
        logic                         last_face;
    } t_face_in;

    // Face after orientation: area is widened so that negation is exact
    typedef struct packed {
        logic [COMPS-1:0][DATA_W-1:0] vel;
        logic [COMPS-1:0][OPB_W-1:0]  area;
        logic [COMPS-1:0][DATA_W-1:0] centre;
        logic                         last_face;
    } t_face;

    typedef struct packed {
        logic [COMPS-1:0][RES_W-1:0] force_tot;
        logic [COMPS-1:0][RES_W-1:0] moment_tot;
    } t_result;

    typedef struct packed {
        logic              start;
        logic              clr;
        logic              sub;
        logic [DSEL_W-1:0] ndig;
        logic [ACC_W-1:0]  a;
        logic [OPB_W-1:0]  b;
    } t_mac_req;

    function automatic t_mac_req mk_req(input logic clr, input logic sub,
                                        input logic [DSEL_W-1:0] ndig,
                                        input logic [ACC_W-1:0] a,
                                        input logic [OPB_W-1:0] b);
        t_mac_req r;
        r.start = 1'b0;
        r.clr   = clr;
        r.sub   = sub;
        r.ndig  = ndig;
        r.a     = a;
        r.b     = b;
        return r;
    endfunction

    function automatic logic [RES_W-1:0] sat64(input logic [ACC_W-1:0] x);
        logic [RES_W-1:0] r;
        if (x[ACC_W-1:RES_W-1] == {(ACC_W-RES_W+1){x[RES_W-1]}}) begin
            r = x[RES_W-1:0];
        end else begin
            r = {x[ACC_W-1], {(RES_W-1){~x[ACC_W-1]}}};
        end
        return r;
    endfunction

    function automatic logic [RES_W-1:0] sat_add64(input logic [RES_W-1:0] a,
                                                   input logic [RES_W-1:0] b);
        logic [RES_W:0]   s;
        logic [RES_W-1:0] r;
        s = {a[RES_W-1], a} + {b[RES_W-1], b};
        if (s[RES_W] == s[RES_W-1]) begin
            r = s[RES_W-1:0];
        end else begin
            r = {s[RES_W], {(RES_W-1){~s[RES_W]}}};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fmf_mac.sv =====
// Digit-serial signed multiply-accumulate unit: wide operand times 33-bit operand.
module fmf_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fmf_pkg::t_mac_req         i_req,
    output logic                      o_busy,
    output logic [fmf_pkg::ACC_W-1:0] o_acc
);
    import fmf_pkg::*;

    logic                      r_active;
    logic                      r_pv;
    logic [ACC_W-1:0]          r_a;
    logic signed [OPB_W-1:0]   r_b;
    logic [DSEL_W-1:0]         r_dig;
    logic [DSEL_W-1:0]         r_last;
    logic [DSEL_W-1:0]         r_pdig;
    logic                      r_sub;
    logic signed [2*OPB_W-1:0] r_prod;
    logic [ACC_W-1:0]          r_acc;

    logic [DIG_W-1:0]          dig_bits;
    logic signed [OPB_W-1:0]   dig_op;
    logic [ACC_W-1:0]          prod_ext;
    logic [ACC_W-1:0]          prod_sh;

    // lower digits are unsigned, the top digit carries the sign
    assign dig_bits = r_a[r_dig*DIG_W +: DIG_W];
    assign dig_op   = (r_dig == r_last) ? $signed({dig_bits[DIG_W-1], dig_bits})
                                        : $signed({1'b0, dig_bits});
    assign prod_ext = ACC_W'(r_prod);
    assign prod_sh  = prod_ext << (r_pdig * DIG_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_active <= 1'b1;
            end else if (r_active && (r_dig == r_last)) begin
                r_active <= 1'b0;
            end
            r_pv <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a;
            r_b    <= $signed(i_req.b);
            r_last <= i_req.ndig;
            r_sub  <= i_req.sub;
            r_dig  <= '0;
        end else if (r_active) begin
            r_dig <= r_dig + 1'b1;
        end
        r_prod <= dig_op * r_b;
        r_pdig <= r_dig;
        if (i_req.start && i_req.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_sub ? (r_acc - prod_sh) : (r_acc + prod_sh);
        end
    end

    assign o_busy = r_active | r_pv;
    assign o_acc  = r_acc;

endmodule

// ===== hw/rtl/fmf_front.sv =====
// Front end: takes a face, forms the orientation dot product and turns the area inward.
module fmf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fmf_pkg::t_face_in i_face,
    output logic              o_full,
    input  fmf_pkg::t_cfg     i_cfg,
    output logic              o_q_push,
    output fmf_pkg::t_face    o_q_entry,
    input  logic              i_q_full
);
    import fmf_pkg::*;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_ISSUE = 2'd1;
    localparam logic [1:0] F_WAIT  = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [1:0]       r_step;
    t_face_in         r_in;

    t_mac_req         req;
    logic             mac_busy;
    logic [ACC_W-1:0] mac_acc;
    logic             flip;
    logic [OPB_W-1:0] area_w;
    logic [OPB_W-1:0] rel_b;

    assign rel_b = OPB_W'($signed(r_in.centre[r_step])) - OPB_W'($signed(i_cfg.cv[r_step]));

    always_comb begin
        req       = mk_req(r_step == 2'd0, 1'b0, DIGITS_1,
                           ACC_W'($signed(r_in.area[r_step])), rel_b);
        req.start = (r_state == F_ISSUE);
    end

    fmf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    // strictly positive dot product: area points away from the CV point
    assign flip = !mac_acc[ACC_W-1] && (mac_acc != '0);

    always_comb begin
        area_w              = '0;
        o_q_entry.vel       = r_in.vel;
        o_q_entry.centre    = r_in.centre;
        o_q_entry.last_face = r_in.last_face;
        for (int i = 0; i < COMPS; i++) begin
            area_w            = OPB_W'($signed(r_in.area[i]));
            o_q_entry.area[i] = flip ? (~area_w + 1'b1) : area_w;
        end
    end

    assign o_full   = (r_state != F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_push) n_state = F_ISSUE;
            F_ISSUE: n_state = F_WAIT;
            F_WAIT: begin
                if (!mac_busy) begin
                    n_state = (r_step == 2'(COMPS - 1)) ? F_PUSH : F_ISSUE;
                end
            end
            F_PUSH:  if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_IDLE) begin
                r_step <= '0;
            end else if ((r_state == F_WAIT) && !mac_busy && (r_step != 2'(COMPS - 1))) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && i_push) begin
            r_in <= i_face;
        end
    end

endmodule

// ===== hw/rtl/fmf_queue.sv =====
// Two-entry queue of oriented faces between the front and back ends.
module fmf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fmf_pkg::t_face i_data,
    output logic           o_full,
    input  logic           i_pop,
    output fmf_pkg::t_face o_data,
    output logic           o_empty
);
    import fmf_pkg::*;

    t_face             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/fmf_back.sv =====
// Back end: sequences force and moment through a shared MAC and keeps the running totals.
module fmf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  fmf_pkg::t_face   i_q_data,
    output logic             o_q_pop,
    input  fmf_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    input  logic             i_res_pop,
    output fmf_pkg::t_result o_res
);
    import fmf_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_ISSUE = 2'd1;
    localparam logic [1:0] B_WAIT  = 2'd2;
    localparam logic [1:0] B_ACC   = 2'd3;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(20);

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [STEP_W-1:0]           r_step;
    t_face                       r_face;
    logic [COMPS-1:0][OPB_W-1:0] r_d;
    logic [VV_W-1:0]             r_vv;
    logic [VS2_W-1:0]            r_vs2;
    logic [BQ_W-1:0]             r_bq;
    logic [COMPS-1:0][RES_W-1:0] r_f;
    logic [COMPS-1:0][RES_W-1:0] r_m;
    logic [COMPS-1:0][RES_W-1:0] r_ftot;
    logic [COMPS-1:0][RES_W-1:0] r_mtot;
    logic [COMPS-1:0][RES_W-1:0] n_ftot;
    logic [COMPS-1:0][RES_W-1:0] n_mtot;
    t_result                     r_out;
    logic                        r_out_valid;

    logic [ACC_W-1:0]            vel_a [COMPS];
    logic [OPB_W-1:0]            vel_b [COMPS];
    logic [ACC_W-1:0]            f_a   [COMPS];
    logic [ACC_W-1:0]            vv_a;
    logic [ACC_W-1:0]            vs2_a;
    logic [ACC_W-1:0]            bq_a;
    logic [OPB_W-1:0]            den_b;

    t_mac_req                    req;
    logic                        mac_busy;
    logic [ACC_W-1:0]            mac_acc;
    logic                        op_done;
    logic                        acc_go;
    logic [RES_W-1:0]            f_new;
    logic [RES_W-1:0]            m_new;

    always_comb begin
        for (int i = 0; i < COMPS; i++) begin
            vel_a[i] = ACC_W'($signed(r_face.vel[i]));
            vel_b[i] = OPB_W'($signed(r_face.vel[i]));
            f_a[i]   = ACC_W'($signed(r_f[i]));
        end
    end

    assign vv_a  = ACC_W'($signed(r_vv));
    assign vs2_a = ACC_W'($signed(r_vs2));
    assign bq_a  = ACC_W'($signed(r_bq));
    assign den_b = OPB_W'(i_cfg.density);

    // vv, then v.s, then per axis b = (s*vv - v*2vs) >>> 1 and f = den*b,
    // then the three cross-product components
    always_comb begin
        req = mk_req(1'b1, 1'b0, DIGITS_1, vel_a[0], vel_b[0]);
        unique case (r_step)
            5'd0:    req = mk_req(1'b1, 1'b0, DIGITS_1, vel_a[0], vel_b[0]);
            5'd1:    req = mk_req(1'b0, 1'b0, DIGITS_1, vel_a[1], vel_b[1]);
            5'd2:    req = mk_req(1'b0, 1'b0, DIGITS_1, vel_a[2], vel_b[2]);
            5'd3:    req = mk_req(1'b1, 1'b0, DIGITS_1, vel_a[0], r_face.area[0]);
            5'd4:    req = mk_req(1'b0, 1'b0, DIGITS_1, vel_a[1], r_face.area[1]);
            5'd5:    req = mk_req(1'b0, 1'b0, DIGITS_1, vel_a[2], r_face.area[2]);
            5'd6:    req = mk_req(1'b1, 1'b0, DIGITS_3, vv_a, r_face.area[0]);
            5'd7:    req = mk_req(1'b0, 1'b1, DIGITS_3, vs2_a, vel_b[0]);
            5'd8:    req = mk_req(1'b1, 1'b0, DIGITS_4, bq_a, den_b);
            5'd9:    req = mk_req(1'b1, 1'b0, DIGITS_3, vv_a, r_face.area[1]);
            5'd10:   req = mk_req(1'b0, 1'b1, DIGITS_3, vs2_a, vel_b[1]);
            5'd11:   req = mk_req(1'b1, 1'b0, DIGITS_4, bq_a, den_b);
            5'd12:   req = mk_req(1'b1, 1'b0, DIGITS_3, vv_a, r_face.area[2]);
            5'd13:   req = mk_req(1'b0, 1'b1, DIGITS_3, vs2_a, vel_b[2]);
            5'd14:   req = mk_req(1'b1, 1'b0, DIGITS_4, bq_a, den_b);
            5'd15:   req = mk_req(1'b1, 1'b0, DIGITS_2, f_a[2], r_d[1]);
            5'd16:   req = mk_req(1'b0, 1'b1, DIGITS_2, f_a[1], r_d[2]);
            5'd17:   req = mk_req(1'b1, 1'b0, DIGITS_2, f_a[0], r_d[2]);
            5'd18:   req = mk_req(1'b0, 1'b1, DIGITS_2, f_a[2], r_d[0]);
            5'd19:   req = mk_req(1'b1, 1'b0, DIGITS_2, f_a[1], r_d[0]);
            5'd20:   req = mk_req(1'b0, 1'b1, DIGITS_2, f_a[0], r_d[1]);
            default: req = mk_req(1'b1, 1'b0, DIGITS_1, vel_a[0], vel_b[0]);
        endcase
        req.start = (r_state == B_ISSUE);
    end

    fmf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    assign op_done = (r_state == B_WAIT) && !mac_busy;
    assign acc_go  = (r_state == B_ACC) && (!r_face.last_face || !r_out_valid);
    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign f_new   = sat64($signed(mac_acc) >>> FORCE_SHIFT);
    assign m_new   = sat64($signed(mac_acc) >>> MOMENT_SHIFT);

    always_comb begin
        for (int i = 0; i < COMPS; i++) begin
            n_ftot[i] = sat_add64(r_ftot[i], r_f[i]);
            n_mtot[i] = sat_add64(r_mtot[i], r_m[i]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_ISSUE;
            B_ISSUE: n_state = B_WAIT;
            B_WAIT: begin
                if (!mac_busy) begin
                    n_state = (r_step == STEP_LAST) ? B_ACC : B_ISSUE;
                end
            end
            B_ACC:   if (acc_go) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_ftot      <= '0;
            r_mtot      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_IDLE) begin
                r_step <= '0;
            end else if (op_done && (r_step != STEP_LAST)) begin
                r_step <= r_step + 1'b1;
            end
            if (i_res_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (acc_go) begin
                if (r_face.last_face) begin
                    r_out_valid <= 1'b1;
                    r_ftot      <= '0;
                    r_mtot      <= '0;
                end else begin
                    r_ftot <= n_ftot;
                    r_mtot <= n_mtot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_face <= i_q_data;
            for (int i = 0; i < COMPS; i++) begin
                r_d[i] <= OPB_W'($signed(i_q_data.centre[i])) - OPB_W'($signed(i_cfg.org[i]));
            end
        end
        if (acc_go && r_face.last_face) begin
            r_out.force_tot  <= n_ftot;
            r_out.moment_tot <= n_mtot;
        end
        if (op_done) begin
            unique case (r_step)
                5'd2:    r_vv  <= mac_acc[VV_W-1:0];
                5'd5:    r_vs2 <= {mac_acc[VS2_W-2:0], 1'b0};
                5'd7,
                5'd10,
                5'd13:   r_bq  <= mac_acc[BQ_W:1];
                5'd8:    r_f[0] <= f_new;
                5'd11:   r_f[1] <= f_new;
                5'd14:   r_f[2] <= f_new;
                5'd16:   r_m[0] <= m_new;
                5'd18:   r_m[1] <= m_new;
                5'd20:   r_m[2] <= m_new;
                default: ;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== hw/rtl/face_momentum_flux_accumulator_core.sv =====
// Top level of the face momentum flux accumulator: configuration registers and core wiring.
// A face marked last passes the front end, the queue, the back end's MAC work and the total
//   update before its result shows. The back end's single 33x33-bit MAC works through 21
//   digit-serial operations per face and sets the pace; the front end can take the next face
//   while the back end is busy.
// Reset: synchronous, active low; clears both totals and queues, sets the CV point and origin
//   to zero and density to 1.0. No clearing pass: the block takes faces straight after reset.
module face_momentum_flux_accumulator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // face input, queue style
    input  logic                            push,
    output logic                            full,
    input  logic signed [31:0]              i_vel_x,
    input  logic signed [31:0]              i_vel_y,
    input  logic signed [31:0]              i_vel_z,
    input  logic signed [31:0]              i_area_x,
    input  logic signed [31:0]              i_area_y,
    input  logic signed [31:0]              i_area_z,
    input  logic signed [31:0]              i_centre_x,
    input  logic signed [31:0]              i_centre_y,
    input  logic signed [31:0]              i_centre_z,
    input  logic                            i_last_face,
    // result output, queue style
    output logic                            empty,
    input  logic                            pop,
    output logic signed [63:0]              o_force_x,
    output logic signed [63:0]              o_force_y,
    output logic signed [63:0]              o_force_z,
    output logic signed [63:0]              o_moment_x,
    output logic signed [63:0]              o_moment_y,
    output logic signed [63:0]              o_moment_z,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fmf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fmf_pkg::DATA_W-1:0]      i_cfg_data
);
    import fmf_pkg::*;

    t_cfg     r_cfg;
    t_face_in face_in;
    t_face    q_wdata;
    t_face    q_rdata;
    t_result  res;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    logic     res_valid;

    // Config writes are always taken; the user only writes while the block is idle.
    // An index past the density register is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cv      <= '0;
            r_cfg.org     <= '0;
            r_cfg.density <= DENSITY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CV_X:    r_cfg.cv[0]   <= i_cfg_data;
                REG_CV_Y:    r_cfg.cv[1]   <= i_cfg_data;
                REG_CV_Z:    r_cfg.cv[2]   <= i_cfg_data;
                REG_ORG_X:   r_cfg.org[0]  <= i_cfg_data;
                REG_ORG_Y:   r_cfg.org[1]  <= i_cfg_data;
                REG_ORG_Z:   r_cfg.org[2]  <= i_cfg_data;
                REG_DENSITY: r_cfg.density <= i_cfg_data[DEN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign face_in.vel       = {i_vel_z, i_vel_y, i_vel_x};
    assign face_in.area      = {i_area_z, i_area_y, i_area_x};
    assign face_in.centre    = {i_centre_z, i_centre_y, i_centre_x};
    assign face_in.last_face = i_last_face;

    // Front end: one face at a time; full stays high from the transfer in until the
    // oriented face has gone into the queue.
    fmf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_face    (face_in),
        .o_full    (full),
        .i_cfg     (r_cfg),
        .o_q_push  (q_push),
        .o_q_entry (q_wdata),
        .i_q_full  (q_full)
    );

    // Short queue so the front can classify the next face while the back is busy.
    fmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back end: force, moment and the saturating totals. The result sits in an output
    // register, so the back end keeps working on later faces while it waits for pop;
    // it only stalls if a second last face completes before the first result leaves.
    fmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .i_res_pop   (pop),
        .o_res       (res)
    );

    assign empty      = !res_valid;
    assign o_force_x  = res.force_tot[0];
    assign o_force_y  = res.force_tot[1];
    assign o_force_z  = res.force_tot[2];
    assign o_moment_x = res.moment_tot[0];
    assign o_moment_y = res.moment_tot[1];
    assign o_moment_z = res.moment_tot[2];

endmodule

// ===== hw/rtl/fmf_checker.sv =====
// Port-level checker for the accumulator core and its bind to the top level.
module fmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_force_x,
    input logic [63:0] o_moment_z
);

    // reset leaves no result waiting
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible after reset");

    // front end is busy for at least the cycle after a face transfer
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front end ready straight after a face transfer");

    // single output register: taking the result always leaves it empty in the cycle after
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty)
        else $error("new result appeared in the cycle after a result transfer");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_force_x) && $stable(o_moment_z)))
        else $error("waiting result changed or vanished");

endmodule

bind face_momentum_flux_accumulator_core fmf_checker u_fmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_force_x  (o_force_x),
    .o_moment_z (o_moment_z)
);
